[rtl/wsp_pkg.sv]
package wsp_pkg;

   // Event kinds carried in the input tuser field.
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_CAPTURE = 2'd1;
   localparam logic [1:0] FUNC_BYTE    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_POLE_COUNT      = 2'd0;
   localparam logic [1:0] REG_SPEED_CONSTANT  = 2'd1;
   localparam logic [1:0] REG_SPEED_CAP       = 2'd2;
   localparam logic [1:0] REG_IDLE_TICK_LIMIT = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [6:0] POLE_COUNT_RESET      = 7'd13;
   localparam logic [9:0] SPEED_CONSTANT_RESET  = 10'd295;
   localparam logic [7:0] SPEED_CAP_RESET       = 8'd99;
   localparam logic [7:0] IDLE_TICK_LIMIT_RESET = 8'd10;
   localparam logic [7:0] CIRCUMFERENCE_RESET   = 8'd220;

   // Dividend is speed_constant * circumference, divisor is period * pole_count.
   localparam int NUM_W = 18;
   localparam int DEN_W = 23;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(NUM_W - 1);

   typedef struct packed {
      logic capture;
      logic store_char;
      logic tick_speed;
      logic tick_idle;
      logic div_init;
      logic div_step;
      logic load_quotient;
      logic enter_setup;
   } cmd_type;

   typedef struct packed {
      logic       setup_active;
      logic       period_ready;
      logic       idle_over;
      logic       div_last;
   } status_type;

endpackage

[rtl/wsp_dp.sv]
module wsp_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [15:0]                      period,
   input  logic [7:0]                       char_value,
   input  logic                             csr_we,
   input  logic [wsp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wsp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wsp_pkg::cmd_type                 cmd,
   output wsp_pkg::status_type              status,
   output logic [7:0]                       shown_value,
   output logic                             hex_mode,
   output logic                             dot_one,
   output logic                             dot_two,
   output logic                             in_setup,
   output logic                             last
);

   logic [6:0] pole_count_ff, pole_count_in;
   logic [9:0] speed_constant_ff, speed_constant_in;
   logic [7:0] speed_cap_ff, speed_cap_in;
   logic [7:0] idle_tick_limit_ff, idle_tick_limit_in;

   logic [15:0] pending_ff, pending_in;
   logic        ready_ff, ready_in;
   logic [7:0]  idle_ff, idle_in;
   logic        setup_ff, setup_in;
   logic [7:0]  circ_ff, circ_in;
   logic        dot1_ff, dot1_in;
   logic        dot2_ff, dot2_in;

   logic [wsp_pkg::NUM_W-1:0] num_ff, num_in;
   logic [wsp_pkg::DEN_W-1:0] den_ff, den_in;
   logic [wsp_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [wsp_pkg::NUM_W-1:0] quot_ff, quot_in;
   logic [wsp_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [7:0] shown_ff, shown_in;
   logic       hex_ff, hex_in;
   logic       last_ff, last_in;

   logic [7:0]                idle_next;
   logic [wsp_pkg::DEN_W:0]   shifted;
   logic [wsp_pkg::DEN_W:0]   trial;
   logic [7:0]                speed;

   assign idle_next = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;

   // One restoring division step: bring in the next dividend bit and try the subtraction.
   assign shifted = {rem_ff, quot_ff[wsp_pkg::NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      if (den_ff == '0) begin
         speed = speed_cap_ff;
      end else if (quot_ff > {{(wsp_pkg::NUM_W-8){1'b0}}, speed_cap_ff}) begin
         speed = speed_cap_ff;
      end else begin
         speed = quot_ff[7:0];
      end
   end

   always_comb begin
      pole_count_in      = pole_count_ff;
      speed_constant_in  = speed_constant_ff;
      speed_cap_in       = speed_cap_ff;
      idle_tick_limit_in = idle_tick_limit_ff;
      if (csr_we) begin
         case (csr_index)
            wsp_pkg::REG_POLE_COUNT:      pole_count_in      = csr_wdata[6:0];
            wsp_pkg::REG_SPEED_CONSTANT:  speed_constant_in  = csr_wdata[9:0];
            wsp_pkg::REG_SPEED_CAP:       speed_cap_in       = csr_wdata[7:0];
            wsp_pkg::REG_IDLE_TICK_LIMIT: idle_tick_limit_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pending_in = pending_ff;
      ready_in   = ready_ff;
      idle_in    = idle_ff;
      setup_in   = setup_ff;
      circ_in    = circ_ff;
      dot1_in    = dot1_ff;
      dot2_in    = dot2_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      shown_in   = shown_ff;
      hex_in     = hex_ff;
      last_in    = last_ff;

      if (cmd.capture) begin
         pending_in = period;
         ready_in   = 1'b1;
      end
      if (cmd.store_char) begin
         circ_in  = char_value;
         shown_in = char_value;
         hex_in   = 1'b1;
         last_in  = 1'b1;
      end
      if (cmd.tick_speed) begin
         ready_in = 1'b0;
         idle_in  = '0;
         dot2_in  = ~dot2_ff;
         num_in   = {8'b0, speed_constant_ff} * {10'b0, circ_ff};
         den_in   = {7'b0, pending_ff} * {16'b0, pole_count_ff};
      end
      if (cmd.tick_idle) begin
         idle_in  = idle_next;
         dot1_in  = ~dot1_ff;
         shown_in = '0;
         hex_in   = 1'b0;
         last_in  = ~(idle_next > idle_tick_limit_ff);
      end
      if (cmd.div_init) begin
         rem_in  = '0;
         quot_in = num_ff;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         if (!trial[wsp_pkg::DEN_W]) begin
            rem_in = trial[wsp_pkg::DEN_W-1:0];
         end else begin
            rem_in = shifted[wsp_pkg::DEN_W-1:0];
         end
         quot_in = {quot_ff[wsp_pkg::NUM_W-2:0], ~trial[wsp_pkg::DEN_W]};
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.load_quotient) begin
         shown_in = speed;
         hex_in   = 1'b0;
         last_in  = 1'b1;
      end
      if (cmd.enter_setup) begin
         setup_in = 1'b1;
         shown_in = circ_ff;
         hex_in   = 1'b1;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_count_ff      <= wsp_pkg::POLE_COUNT_RESET;
         speed_constant_ff  <= wsp_pkg::SPEED_CONSTANT_RESET;
         speed_cap_ff       <= wsp_pkg::SPEED_CAP_RESET;
         idle_tick_limit_ff <= wsp_pkg::IDLE_TICK_LIMIT_RESET;
         pending_ff         <= '0;
         ready_ff           <= 1'b0;
         idle_ff            <= '0;
         setup_ff           <= 1'b0;
         circ_ff            <= wsp_pkg::CIRCUMFERENCE_RESET;
         dot1_ff            <= 1'b0;
         dot2_ff            <= 1'b0;
      end else begin
         pole_count_ff      <= pole_count_in;
         speed_constant_ff  <= speed_constant_in;
         speed_cap_ff       <= speed_cap_in;
         idle_tick_limit_ff <= idle_tick_limit_in;
         pending_ff         <= pending_in;
         ready_ff           <= ready_in;
         idle_ff            <= idle_in;
         setup_ff           <= setup_in;
         circ_ff            <= circ_in;
         dot1_ff            <= dot1_in;
         dot2_ff            <= dot2_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      shown_ff <= shown_in;
      hex_ff   <= hex_in;
      last_ff  <= last_in;
   end

   assign status.setup_active = setup_ff;
   assign status.period_ready = ready_ff;
   assign status.idle_over    = idle_next > idle_tick_limit_ff;
   assign status.div_last     = cnt_ff == wsp_pkg::DIV_LAST_STEP;

   assign shown_value = shown_ff;
   assign hex_mode    = hex_ff;
   assign dot_one     = dot1_ff;
   assign dot_two     = dot2_ff;
   assign in_setup    = setup_ff;
   assign last        = last_ff;

endmodule

[rtl/wsp_ctrl.sv]
module wsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wsp_pkg::status_type status,
   output wsp_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_PREP       = 6'b000010,
      S_DIV        = 6'b000100,
      S_FINISH     = 6'b001000,
      S_SEND_FIRST = 6'b010000,
      S_SEND       = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = (state_ff == S_SEND) || (state_ff == S_SEND_FIRST);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  wsp_pkg::FUNC_CAPTURE: begin
                     cmd.capture = 1'b1;
                  end
                  wsp_pkg::FUNC_BYTE: begin
                     if (status.setup_active) begin
                        cmd.store_char = 1'b1;
                        state_in       = S_SEND;
                     end
                  end
                  wsp_pkg::FUNC_TICK: begin
                     if (!status.setup_active) begin
                        if (status.period_ready) begin
                           cmd.tick_speed = 1'b1;
                           state_in       = S_PREP;
                        end else begin
                           cmd.tick_idle = 1'b1;
                           state_in      = status.idle_over ? S_SEND_FIRST : S_SEND;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.load_quotient = 1'b1;
            state_in          = S_SEND;
         end
         S_SEND_FIRST: begin
            // The setup-mode result follows once the last normal result is taken.
            if (rsp_ready) begin
               cmd.enter_setup = 1'b1;
               state_in        = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_while_sending: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input taken while a result is pending");

   a_div_runs_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_FINISH))
      else $error("divider left early");

   a_prep_starts_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP) |=> (state_ff == S_DIV)) else $error("divider not started");

   a_setup_follows_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND_FIRST && rsp_ready) |=> (state_ff == S_SEND && status.setup_active))
      else $error("setup result missing");

endmodule

[rtl/wheel_speed_from_period_core.sv]
// Bicycle speed display core. Input transactions carry an event kind in req_tuser: a tick,
// a magnet period capture or a received byte. A capture is stored as pending and gives no
// result. In normal mode a tick with a pending period shows speed_constant * circumference /
// (period * pole_count), limited to speed_cap (a zero divisor also gives speed_cap) and toggles
// dot two; a tick without one shows zero, toggles dot one and counts an idle tick. When the idle
// count passes idle_tick_limit the core shows the circumference in hex and stays in setup mode
// until reset, where each received byte replaces the circumference. The core handles one
// transaction at a time, each result waiting for its handshake; a speed tick runs the 18-step
// restoring divider before its result. Configuration registers are written through
// csr_we/csr_index/csr_wdata; the user must write only while idle (not enforced by the core).
module wheel_speed_from_period_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // period[15:0], char_value[23:16]
   input  logic [1:0]                       req_tuser,  // func[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // shown_value[7:0], dot_one[8],
                                                        // dot_two[9], in_setup[10], zero
   output logic                             rsp_tuser,  // hex_mode[0]
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [wsp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   wsp_pkg::cmd_type    cmd;
   wsp_pkg::status_type status;
   logic [7:0]          shown_value;
   logic                dot_one;
   logic                dot_two;
   logic                in_setup;

   wsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   wsp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .period      (req_tdata[15:0]),
      .char_value  (req_tdata[23:16]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .shown_value (shown_value),
      .hex_mode    (rsp_tuser),
      .dot_one     (dot_one),
      .dot_two     (dot_two),
      .in_setup    (in_setup),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, in_setup, dot_two, dot_one, shown_value};

endmodule
